// ----- design/vat_pkg.sv -----
// ----------------------------------------------------------------------------
// Vertex affine transform package
// Shared constants, payload types and pipeline control for the transform.
// ----------------------------------------------------------------------------
`default_nettype none

package vat_pkg;

  localparam int COORD_WIDTH_DEF    = 32;
  localparam int COEFF_WIDTH_DEF    = 16;
  localparam int MAX_ATTR_BYTES_DEF = 16;
  localparam int FRAC_BITS          = 12;
  localparam int COEFF_SLOT         = 16;
  localparam int NUM_LANES          = 6;
  localparam int CFG_IDX_W          = 3;
  localparam int CFG_DATA_W         = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE     = 3'd0,
    CFG_X_COEFFS   = 3'd1,
    CFG_Y_COEFFS   = 3'd2,
    CFG_Z_COEFFS   = 3'd3,
    CFG_SHIFT_XY   = 3'd4,
    CFG_SHIFT_Z    = 3'd5,
    CFG_ATTR_BYTES = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic signed [31:0] norm_z;
    logic [63:0]        attr_low;
    logic [63:0]        attr_high;
    logic               last_vertex;
  } vertex_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_norm_x;
    logic signed [31:0] out_norm_y;
    logic signed [31:0] out_norm_z;
    logic [63:0]        out_attr_low;
    logic [63:0]        out_attr_high;
    logic               out_last;
  } result_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
  } pipe_ctl_t;

endpackage

`default_nettype wire

// ----- design/vat_lane.sv -----
// ----------------------------------------------------------------------------
// Vertex affine transform lane
// One output row: three registered products, floor shift, sum with an
// offset and saturation to the coordinate range.
// ----------------------------------------------------------------------------
`default_nettype none

module vat_lane
  import vat_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int COEFF_WIDTH = COEFF_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire pipe_ctl_t                ctl,
  input  wire logic [3*COORD_WIDTH-1:0] vec,
  input  wire logic [3*COEFF_WIDTH-1:0] coef,
  input  wire logic [COORD_WIDTH-1:0]   offset,
  output logic [COORD_WIDTH-1:0]        result
);

  localparam int PW  = COORD_WIDTH + COEFF_WIDTH;
  localparam int SHW = PW - FRAC_BITS;
  localparam int SW  = ((SHW > COORD_WIDTH) ? SHW : COORD_WIDTH) + 2;
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-COORD_WIDTH+1){1'b0}},
                                             {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-COORD_WIDTH+1){1'b1}},
                                             {(COORD_WIDTH-1){1'b0}}};

  logic signed [PW-1:0]          prod [3];
  logic signed [COORD_WIDTH-1:0] off_q;
  logic signed [SW-1:0]          sum;

  always_ff @(posedge clk) begin
    if (ctl.load_a) begin
      for (int i = 0; i < 3; i++) begin
        prod[i] <= PW'($signed(vec[i*COORD_WIDTH +: COORD_WIDTH]))
                 * PW'($signed(coef[i*COEFF_WIDTH +: COEFF_WIDTH]));
      end
      off_q <= $signed(offset);
    end
  end

  always_comb begin
    sum = SW'(off_q);
    for (int i = 0; i < 3; i++) begin
      sum = sum + SW'($signed(prod[i][PW-1:FRAC_BITS]));
    end
    if (sum > SAT_HI) begin
      result = SAT_HI[COORD_WIDTH-1:0];
    end else if (sum < SAT_LO) begin
      result = SAT_LO[COORD_WIDTH-1:0];
    end else begin
      result = sum[COORD_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- design/vat_merge.sv -----
// ----------------------------------------------------------------------------
// Vertex affine transform merge stage
// Holds the side data of a vertex, masks its attributes and combines the
// lane results or the copied coordinates into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vat_merge
  import vat_pkg::*;
#(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int MAX_ATTR_BYTES = MAX_ATTR_BYTES_DEF
) (
  input  wire logic                             clk,
  input  wire pipe_ctl_t                        ctl,
  input  wire logic                             enable,
  input  wire logic [4:0]                       attr_count,
  input  wire vertex_t                          vtx,
  input  wire logic [NUM_LANES*COORD_WIDTH-1:0] lane_res,
  output result_t                               res
);

  logic         xf_q;
  vertex_t      item_q;
  vertex_t      item_next;
  logic [4:0]   cnt;
  logic [127:0] attr_in;
  logic [127:0] attr_kept;
  result_t      res_next;

  always_comb begin
    cnt = (attr_count > 5'(MAX_ATTR_BYTES)) ? 5'(MAX_ATTR_BYTES) : attr_count;
    attr_in = {vtx.attr_high, vtx.attr_low};
    for (int b = 0; b < 16; b++) begin
      attr_kept[b*8 +: 8] = (5'(b) < cnt) ? attr_in[b*8 +: 8] : 8'h00;
    end
    item_next           = vtx;
    item_next.attr_low  = attr_kept[63:0];
    item_next.attr_high = attr_kept[127:64];
  end

  always_ff @(posedge clk) begin
    if (ctl.load_a) begin
      xf_q   <= enable;
      item_q <= item_next;
    end
  end

  always_comb begin
    res_next.out_attr_low  = item_q.attr_low;
    res_next.out_attr_high = item_q.attr_high;
    res_next.out_last      = item_q.last_vertex;
    if (xf_q) begin
      res_next.out_pos_x  = 32'($signed(lane_res[0*COORD_WIDTH +: COORD_WIDTH]));
      res_next.out_pos_y  = 32'($signed(lane_res[1*COORD_WIDTH +: COORD_WIDTH]));
      res_next.out_pos_z  = 32'($signed(lane_res[2*COORD_WIDTH +: COORD_WIDTH]));
      res_next.out_norm_x = 32'($signed(lane_res[3*COORD_WIDTH +: COORD_WIDTH]));
      res_next.out_norm_y = 32'($signed(lane_res[4*COORD_WIDTH +: COORD_WIDTH]));
      res_next.out_norm_z = 32'($signed(lane_res[5*COORD_WIDTH +: COORD_WIDTH]));
    end else begin
      res_next.out_pos_x  = 32'($signed(item_q.pos_x[COORD_WIDTH-1:0]));
      res_next.out_pos_y  = 32'($signed(item_q.pos_y[COORD_WIDTH-1:0]));
      res_next.out_pos_z  = 32'($signed(item_q.pos_z[COORD_WIDTH-1:0]));
      res_next.out_norm_x = 32'($signed(item_q.norm_x[COORD_WIDTH-1:0]));
      res_next.out_norm_y = 32'($signed(item_q.norm_y[COORD_WIDTH-1:0]));
      res_next.out_norm_z = 32'($signed(item_q.norm_z[COORD_WIDTH-1:0]));
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_b) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/vertex_affine_transform.sv -----
// ----------------------------------------------------------------------------
// Vertex affine transform
// Stage A registers a transfer, then the result register; throughput is one
// vertex per cycle unless stalled. Six multiply lanes work in parallel.
// Each lane registers three products, then a merge stage registers the sums.
// Reset clears both pipeline valid flags and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_affine_transform
  import vat_pkg::*;
#(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int COEFF_WIDTH    = COEFF_WIDTH_DEF,
  parameter int MAX_ATTR_BYTES = MAX_ATTR_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  input  wire logic                  vtx_valid,
  output logic                       vtx_stall,
  input  wire vertex_t               vtx,
  output logic                       res_valid,
  input  wire logic                  res_stall,
  output result_t                    res
);

  logic        transform_enable;
  logic [47:0] out_x_coeffs;
  logic [47:0] out_y_coeffs;
  logic [47:0] out_z_coeffs;
  logic [63:0] shift_xy;
  logic [31:0] shift_z;
  logic [4:0]  attribute_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      transform_enable <= 1'b0;
      out_x_coeffs     <= 48'h0000_0000_1000;
      out_y_coeffs     <= 48'h0000_1000_0000;
      out_z_coeffs     <= 48'h1000_0000_0000;
      shift_xy         <= '0;
      shift_z          <= '0;
      attribute_bytes  <= 5'd8;
    end else if (wr_en) begin
      case (cfg_index_t'(wr_index))
        CFG_ENABLE:     transform_enable <= wr_data[0];
        CFG_X_COEFFS:   out_x_coeffs     <= wr_data[47:0];
        CFG_Y_COEFFS:   out_y_coeffs     <= wr_data[47:0];
        CFG_Z_COEFFS:   out_z_coeffs     <= wr_data[47:0];
        CFG_SHIFT_XY:   shift_xy         <= wr_data;
        CFG_SHIFT_Z:    shift_z          <= wr_data[31:0];
        CFG_ATTR_BYTES: attribute_bytes  <= wr_data[4:0];
        default: begin
        end
      endcase
    end
  end

  logic      a_valid;
  logic      a_open;
  logic      b_open;
  pipe_ctl_t ctl;

  always_comb begin
    b_open     = !res_valid || !res_stall;
    a_open     = !a_valid || b_open;
    vtx_stall  = !a_open;
    ctl.load_a = vtx_valid && a_open;
    ctl.load_b = a_valid && b_open;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (a_open) begin
        a_valid <= vtx_valid;
      end
      if (b_open) begin
        res_valid <= a_valid;
      end
    end
  end

  logic [3*COORD_WIDTH-1:0]         pos_vec;
  logic [3*COORD_WIDTH-1:0]         norm_vec;
  logic [3*COEFF_WIDTH-1:0]         row_coef [3];
  logic [COORD_WIDTH-1:0]           row_off  [3];
  logic [NUM_LANES*COORD_WIDTH-1:0] lane_res;

  always_comb begin
    pos_vec  = {vtx.pos_z[COORD_WIDTH-1:0], vtx.pos_y[COORD_WIDTH-1:0],
                vtx.pos_x[COORD_WIDTH-1:0]};
    norm_vec = {vtx.norm_z[COORD_WIDTH-1:0], vtx.norm_y[COORD_WIDTH-1:0],
                vtx.norm_x[COORD_WIDTH-1:0]};
    for (int i = 0; i < 3; i++) begin
      row_coef[0][i*COEFF_WIDTH +: COEFF_WIDTH] =
        out_x_coeffs[i*COEFF_SLOT +: COEFF_WIDTH];
      row_coef[1][i*COEFF_WIDTH +: COEFF_WIDTH] =
        out_y_coeffs[i*COEFF_SLOT +: COEFF_WIDTH];
      row_coef[2][i*COEFF_WIDTH +: COEFF_WIDTH] =
        out_z_coeffs[i*COEFF_SLOT +: COEFF_WIDTH];
    end
    row_off[0] = shift_xy[COORD_WIDTH-1:0];
    row_off[1] = shift_xy[32 +: COORD_WIDTH];
    row_off[2] = shift_z[COORD_WIDTH-1:0];
  end

  for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
    vat_lane #(
      .COORD_WIDTH (COORD_WIDTH),
      .COEFF_WIDTH (COEFF_WIDTH)
    ) u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .vec    ((j < 3) ? pos_vec : norm_vec),
      .coef   (row_coef[j % 3]),
      .offset ((j < 3) ? row_off[j % 3] : '0),
      .result (lane_res[j*COORD_WIDTH +: COORD_WIDTH])
    );
  end

  vat_merge #(
    .COORD_WIDTH    (COORD_WIDTH),
    .MAX_ATTR_BYTES (MAX_ATTR_BYTES)
  ) u_merge (
    .clk        (clk),
    .ctl        (ctl),
    .enable     (transform_enable),
    .attr_count (attribute_bytes),
    .vtx        (vtx),
    .lane_res   (lane_res),
    .res        (res)
  );

endmodule

`default_nettype wire

// ----- tb/vat_checker.sv -----
// ----------------------------------------------------------------------------
// Vertex transform checker
// Mirrors the register writes, predicts every accepted vertex and compares
// each result transfer field by field with the oldest prediction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vat_checker
  import vat_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  input  wire logic                  vtx_valid,
  input  wire logic                  vtx_stall,
  input  wire vertex_t               vtx,
  input  wire logic                  res_valid,
  input  wire logic                  res_stall,
  input  wire result_t               res,
  output int                         mismatches,
  output int                         outstanding
);

  localparam int PRINT_LIMIT = 100;

  logic        xform_on;
  logic [47:0] coef_x;
  logic [47:0] coef_y;
  logic [47:0] coef_z;
  logic [63:0] shift_xy_r;
  logic [31:0] shift_z_r;
  logic [4:0]  attr_cnt;

  result_t expected_vertices[$];

  function automatic logic [31:0] affine_row(logic [47:0] c, longint a, longint b,
                                             longint d, longint offset);
    longint acc;
    acc = offset
        + ((a * longint'($signed(c[15:0]))) >>> FRAC_BITS)
        + ((b * longint'($signed(c[31:16]))) >>> FRAC_BITS)
        + ((d * longint'($signed(c[47:32]))) >>> FRAC_BITS);
    if (acc > longint'(32'sh7FFF_FFFF)) begin
      return 32'h7FFF_FFFF;
    end
    if (acc < -longint'(32'sh7FFF_FFFF) - 1) begin
      return 32'h8000_0000;
    end
    return acc[31:0];
  endfunction

  function automatic result_t predict_vertex(vertex_t v);
    result_t     r;
    longint      px, py, pz, nx, ny, nz;
    int unsigned cnt;
    logic [127:0] keep;
    px = longint'($signed(v.pos_x));
    py = longint'($signed(v.pos_y));
    pz = longint'($signed(v.pos_z));
    nx = longint'($signed(v.norm_x));
    ny = longint'($signed(v.norm_y));
    nz = longint'($signed(v.norm_z));
    if (xform_on) begin
      r.out_pos_x  = affine_row(coef_x, px, py, pz, longint'($signed(shift_xy_r[31:0])));
      r.out_pos_y  = affine_row(coef_y, px, py, pz, longint'($signed(shift_xy_r[63:32])));
      r.out_pos_z  = affine_row(coef_z, px, py, pz, longint'($signed(shift_z_r)));
      r.out_norm_x = affine_row(coef_x, nx, ny, nz, 0);
      r.out_norm_y = affine_row(coef_y, nx, ny, nz, 0);
      r.out_norm_z = affine_row(coef_z, nx, ny, nz, 0);
    end else begin
      r.out_pos_x  = v.pos_x;
      r.out_pos_y  = v.pos_y;
      r.out_pos_z  = v.pos_z;
      r.out_norm_x = v.norm_x;
      r.out_norm_y = v.norm_y;
      r.out_norm_z = v.norm_z;
    end
    cnt  = (attr_cnt > MAX_ATTR_BYTES_DEF) ? MAX_ATTR_BYTES_DEF : attr_cnt;
    keep = (cnt >= 16) ? '1 : ((128'd1 << (8 * cnt)) - 128'd1);
    {r.out_attr_high, r.out_attr_low} = {v.attr_high, v.attr_low} & keep;
    r.out_last = v.last_vertex;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      xform_on   <= 1'b0;
      coef_x     <= 48'd4096;
      coef_y     <= 48'd4096 << 16;
      coef_z     <= 48'd4096 << 32;
      shift_xy_r <= '0;
      shift_z_r  <= '0;
      attr_cnt   <= 5'd8;
      expected_vertices.delete();
      outstanding <= 0;
    end else begin
      result_t want;
      if (wr_en) begin
        case (cfg_index_t'(wr_index))
          CFG_ENABLE:     xform_on   <= wr_data[0];
          CFG_X_COEFFS:   coef_x     <= wr_data[47:0];
          CFG_Y_COEFFS:   coef_y     <= wr_data[47:0];
          CFG_Z_COEFFS:   coef_z     <= wr_data[47:0];
          CFG_SHIFT_XY:   shift_xy_r <= wr_data;
          CFG_SHIFT_Z:    shift_z_r  <= wr_data[31:0];
          CFG_ATTR_BYTES: attr_cnt   <= wr_data[4:0];
          default: ;
        endcase
      end
      if (vtx_valid && !vtx_stall) begin
        expected_vertices.push_back(predict_vertex(vtx));
      end
      if (res_valid && !res_stall) begin
        if (expected_vertices.size() == 0) begin
          report_mismatch("result transfer with no vertex outstanding");
        end else begin
          want = expected_vertices.pop_front();
          check_field("out_pos_x", res.out_pos_x, want.out_pos_x);
          check_field("out_pos_y", res.out_pos_y, want.out_pos_y);
          check_field("out_pos_z", res.out_pos_z, want.out_pos_z);
          check_field("out_norm_x", res.out_norm_x, want.out_norm_x);
          check_field("out_norm_y", res.out_norm_y, want.out_norm_y);
          check_field("out_norm_z", res.out_norm_z, want.out_norm_z);
          check_field("out_attr_low", res.out_attr_low, want.out_attr_low);
          check_field("out_attr_high", res.out_attr_high, want.out_attr_high);
          check_field("out_last", res.out_last, want.out_last);
        end
      end
      outstanding <= expected_vertices.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Vertex affine transform testbench
// Drives directed extremes and random vertices under several register
// settings, random input gaps and result stalls; the checker gives the count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import vat_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 100;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 3'd7;

  typedef struct packed {
    logic        en;
    logic [47:0] cx;
    logic [47:0] cy;
    logic [47:0] cz;
    logic [63:0] sxy;
    logic [31:0] sz;
    logic [4:0]  attr;
  } xform_cfg_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data = '0;
  logic                  vtx_valid = 1'b0;
  logic                  vtx_stall;
  vertex_t               vtx = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  result_t               res;

  int   mismatches;
  int   outstanding;
  int   cycle_count = 0;
  int   stall_left = 0;
  logic idle_on = 1'b0;

  vertex_affine_transform dut (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .vtx_valid (vtx_valid),
    .vtx_stall (vtx_stall),
    .vtx       (vtx),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  vat_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .vtx_valid   (vtx_valid),
    .vtx_stall   (vtx_stall),
    .vtx         (vtx),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res         (res),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result stall bursts start at random only while idle_on is set.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      res_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 5);
      res_stall  <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3, 4, 5: return $urandom;
      default: return 32'($urandom_range(0, 32'h1F_FFFF)) - 32'h10_0000;
    endcase
  endfunction

  function automatic logic [15:0] rand_coeff();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3, 4: return 16'($urandom_range(0, 8191)) - 16'd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic xform_cfg_t rand_config();
    xform_cfg_t c;
    c.en   = ($urandom_range(0, 3) != 0);
    c.cx   = {rand_coeff(), rand_coeff(), rand_coeff()};
    c.cy   = {rand_coeff(), rand_coeff(), rand_coeff()};
    c.cz   = {rand_coeff(), rand_coeff(), rand_coeff()};
    c.sxy  = {rand_coord(), rand_coord()};
    c.sz   = rand_coord();
    c.attr = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(17, 31))
                                         : 5'($urandom_range(0, 16));
    return c;
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_t v;
    v.pos_x       = rand_coord();
    v.pos_y       = rand_coord();
    v.pos_z       = rand_coord();
    v.norm_x      = rand_coord();
    v.norm_y      = rand_coord();
    v.norm_z      = rand_coord();
    v.attr_low    = {$urandom, $urandom};
    v.attr_high   = {$urandom, $urandom};
    v.last_vertex = ($urandom_range(0, 7) == 0);
    return v;
  endfunction

  function automatic vertex_t uniform_vertex(logic [31:0] c, logic [63:0] lo,
                                             logic [63:0] hi, logic last);
    vertex_t v;
    v.pos_x       = c;
    v.pos_y       = c;
    v.pos_z       = c;
    v.norm_x      = c;
    v.norm_y      = c;
    v.norm_z      = c;
    v.attr_low    = lo;
    v.attr_high   = hi;
    v.last_vertex = last;
    return v;
  endfunction

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
  endtask

  // Unused upper bits of the writes carry random junk; the spare index gets junk.
  task automatic load_config(xform_cfg_t c);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    put_reg(CFG_ENABLE, {junk[63:1], c.en});
    put_reg(CFG_X_COEFFS, {junk[63:48], c.cx});
    put_reg(CFG_Y_COEFFS, {junk[47:32], c.cy});
    put_reg(CFG_Z_COEFFS, {junk[31:16], c.cz});
    put_reg(CFG_SHIFT_XY, c.sxy);
    put_reg(CFG_SHIFT_Z, {junk[63:32], c.sz});
    put_reg(CFG_ATTR_BYTES, {junk[63:5], c.attr});
    put_reg(CFG_SPARE_INDEX, junk);
    wr_en <= 1'b0;
  endtask

  task automatic send_vertex(vertex_t v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      vtx_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    vtx       <= v;
    vtx_valid <= 1'b1;
    @(posedge clk);
    while (vtx_stall) @(posedge clk);
  endtask

  task automatic drain();
    vtx_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_directed();
    vertex_t v;
    send_vertex(uniform_vertex(32'h0000_0000, '1, '1, 1'b0));
    send_vertex(uniform_vertex(32'h7FFF_FFFF, '1, '1, 1'b1));
    send_vertex(uniform_vertex(32'h8000_0000, 64'h0123_4567_89AB_CDEF,
                               64'hFEDC_BA98_7654_3210, 1'b0));
    send_vertex(uniform_vertex(32'hFFFF_FFFF, {$urandom, $urandom},
                               {$urandom, $urandom}, 1'b1));
    v        = uniform_vertex(32'h0000_0001, '1, '0, 1'b0);
    v.pos_x  = 32'h7FFF_FFFF;
    v.pos_y  = 32'h8000_0000;
    v.pos_z  = 32'hFFFF_FFFF;
    v.norm_y = 32'h0000_1000;
    v.norm_z = 32'hFFFF_F000;
    send_vertex(v);
  endtask

  initial begin
    xform_cfg_t c;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Register defaults after reset: copy mode, eight attribute bytes.
    idle_on = 1'b1;
    send_directed();
    drain();

    c = '{en: 1'b1, cx: 48'd4096, cy: 48'd4096 << 16, cz: 48'd4096 << 32,
          sxy: '0, sz: '0, attr: 5'd16};
    load_config(c);
    send_directed();
    drain();

    c = '{en: 1'b1, cx: {3{16'h7FFF}}, cy: {3{16'h7FFF}}, cz: {3{16'h7FFF}},
          sxy: {2{32'h7FFF_FFFF}}, sz: 32'h7FFF_FFFF, attr: 5'd0};
    load_config(c);
    send_directed();
    drain();

    c = '{en: 1'b1, cx: {3{16'h8000}}, cy: {3{16'h8000}}, cz: {3{16'h8000}},
          sxy: {2{32'h8000_0000}}, sz: 32'h8000_0000, attr: 5'd31};
    load_config(c);
    send_directed();
    drain();

    c = rand_config();
    c.en   = 1'b0;
    c.attr = 5'd5;
    load_config(c);
    send_directed();
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      idle_on = (phase < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      load_config(rand_config());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_vertex(rand_vertex());
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
